### sv/mrsd_pkg.sv
package mrsd_pkg;

    // Field widths fixed by the item format
    localparam int unsigned LEN_W          = 10;
    localparam int unsigned COUNT_W        = 10;
    localparam int unsigned MAX_LENGTH_DEF = 1023;

    // One tabulated length: reachable flag and best piece count
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } entry_t;

    // Broadcast from the head of the row to every cell
    typedef struct packed {
        logic             clear;
        logic             advance;
        entry_t           cand;
        logic [LEN_W-1:0] piece_a;
        logic [LEN_W-1:0] piece_b;
        logic [LEN_W-1:0] piece_c;
    } ctrl_t;

    // Keep the entry with more pieces; an unreachable one never wins
    function automatic entry_t better(input entry_t cur, input entry_t cand);
        entry_t res;
        res = cur;
        if (cand.valid) begin
            if (!cur.valid || (cand.count > cur.count)) begin
                res = cand;
            end
        end
        return res;
    endfunction

endpackage

### sv/max_rod_segments_dp_unit.sv
// Rod cut unit: greatest number of pieces of three allowed lengths that
// add up exactly to a rod length.
//
// Input: an item is taken at a rising edge with start high and busy low;
// rod_length and piece_len_a/b/c are sampled there. busy stays high while
// the item is worked on.
// Output: result_valid is high for exactly one cycle with best_count and
// cut_possible; the receiver cannot stall, so the result must be taken then.
//
// Timing: one length is settled per cycle by a row of MAX_LENGTH cells
// that shift candidate entries toward the head, so an item with rod
// length n keeps busy high until the head reaches length n, and the
// result shows on the cycle after the last busy one.
// A new item may start in the cycle the result is shown.
// A rod longer than MAX_LENGTH is answered as not cuttable without running the row.
//
// Reset: asynchronous rst_n returns the unit to idle with no result
// pending; the cell row is cleared on every accepted item that is not too long.
module max_rod_segments_dp_unit
    import mrsd_pkg::*;
#(
    parameter int unsigned MAX_LENGTH = MAX_LENGTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [LEN_W-1:0]   rod_length,
    input  logic [LEN_W-1:0]   piece_len_a,
    input  logic [LEN_W-1:0]   piece_len_b,
    input  logic [LEN_W-1:0]   piece_len_c,
    output logic               result_valid,
    output logic [COUNT_W-1:0] best_count,
    output logic               cut_possible
);

    localparam int unsigned IW   = $clog2(MAX_LENGTH + 1);
    localparam int unsigned CMPW = (IW > LEN_W) ? IW : LEN_W;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [IW-1:0]      pos_reg;
    logic [IW-1:0]      pos_next;
    logic [LEN_W-1:0]   rod_reg;
    logic [LEN_W-1:0]   rod_next;
    logic [LEN_W-1:0]   pa_reg;
    logic [LEN_W-1:0]   pa_next;
    logic [LEN_W-1:0]   pb_reg;
    logic [LEN_W-1:0]   pb_next;
    logic [LEN_W-1:0]   pc_reg;
    logic [LEN_W-1:0]   pc_next;
    entry_t             head_reg;
    entry_t             head_next;
    logic               rv_reg;
    logic               rv_next;
    logic [COUNT_W-1:0] cnt_reg;
    logic [COUNT_W-1:0] cnt_next;
    logic               poss_reg;
    logic               poss_next;

    logic               accept;
    logic               too_long;
    logic               at_end;
    ctrl_t              ctrl;
    entry_t             merged   [MAX_LENGTH];
    entry_t             right_in [MAX_LENGTH];

    assign busy     = (state_reg == ST_RUN);
    assign accept   = start && !busy;
    assign too_long = (32'(rod_length) > MAX_LENGTH);
    assign at_end   = (CMPW'(pos_reg) == CMPW'(rod_reg));

    // Broadcast the settled head entry, one piece longer, to the row
    always_comb
    begin
        ctrl.clear         = accept && !too_long;
        ctrl.advance       = busy && !at_end;
        ctrl.cand.valid    = busy && !at_end && head_reg.valid;
        ctrl.cand.count    = head_reg.count + COUNT_W'(1);
        ctrl.piece_a       = pa_reg;
        ctrl.piece_b       = pb_reg;
        ctrl.piece_c       = pc_reg;
    end

    // Row of cells, cell k holding the length k + 1 beyond the head
    for (genvar k = 0; k < MAX_LENGTH; k++)
    begin : g_cell
        if (k == MAX_LENGTH - 1)
        begin : g_last
            assign right_in[k] = '0;
        end
        else
        begin : g_mid
            assign right_in[k] = merged[k+1];
        end

        mrsd_cell #(
            .IDX (k)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (ctrl),
            .right  (right_in[k]),
            .merged (merged[k])
        );
    end

    // Sequence one item: answer a too-long rod at once, else load, advance one length a cycle, emit at the end
    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        rod_next   = rod_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        pc_next    = pc_reg;
        head_next  = head_reg;
        rv_next    = 1'b0;
        cnt_next   = cnt_reg;
        poss_next  = poss_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (too_long)
                    begin
                        rv_next   = 1'b1;
                        cnt_next  = '0;
                        poss_next = 1'b0;
                    end
                    else
                    begin
                        state_next       = ST_RUN;
                        pos_next         = '0;
                        rod_next         = rod_length;
                        pa_next          = piece_len_a;
                        pb_next          = piece_len_b;
                        pc_next          = piece_len_c;
                        head_next.valid  = 1'b1;
                        head_next.count  = '0;
                    end
                end
            end
            ST_RUN:
            begin
                if (at_end)
                begin
                    state_next = ST_IDLE;
                    rv_next    = 1'b1;
                    poss_next  = head_reg.valid;
                    cnt_next   = head_reg.valid ? head_reg.count : '0;
                end
                else
                begin
                    pos_next  = pos_reg + IW'(1);
                    head_next = merged[0];
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        rod_reg  <= rod_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        pc_reg   <= pc_next;
        head_reg <= head_next;
        cnt_reg  <= cnt_next;
        poss_reg <= poss_next;
    end

    assign result_valid = rv_reg;
    assign best_count   = cnt_reg;
    assign cut_possible = poss_reg;

    // A result is only shown once the row has stopped
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while still busy");

    // A tabulated item always starts running
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (32'(rod_length) <= MAX_LENGTH)) |=> busy)
        else $error("accepted item did not start");

    // No exact cut means a zero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !cut_possible) |-> (best_count == '0))
        else $error("nonzero count without an exact cut");

    // The head never runs past the rod length
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (CMPW'(pos_reg) <= CMPW'(rod_reg)))
        else $error("head position beyond rod length");

endmodule

### sv/mrsd_cell.sv
module mrsd_cell
    import mrsd_pkg::*;
#(
    parameter int unsigned IDX = 0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  ctrl_t  ctrl,
    input  entry_t right,
    output entry_t merged
);

    // This cell holds the length that lies POS beyond the head
    localparam int unsigned POS = IDX + 1;

    entry_t entry_reg;
    entry_t entry_next;
    logic   hit;

    // Merge in the head's candidate, keeping the better entry, when one piece spans exactly to here
    always_comb
    begin
        hit = ctrl.cand.valid &&
              ((32'(ctrl.piece_a) == POS) ||
               (32'(ctrl.piece_b) == POS) ||
               (32'(ctrl.piece_c) == POS));
        merged = hit ? better(entry_reg, ctrl.cand) : entry_reg;
    end

    // Drop everything on a new item, shift toward the head while running
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.clear)
        begin
            entry_next = '0;
        end
        else if (ctrl.advance)
        begin
            entry_next = right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_reg <= '0;
        end
        else
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mrsd_pkg::*;

    localparam int MAX_LEN      = MAX_LENGTH_DEF;
    localparam int QUIET_LIMIT  = 8000;
    localparam int TAIL_CYCLES  = 40;
    localparam int RANDOM_ITEMS = 560;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [LEN_W-1:0] rod;
        logic [LEN_W-1:0] pa;
        logic [LEN_W-1:0] pb;
        logic [LEN_W-1:0] pc;
    } cut_query_t;

    typedef struct {
        logic [COUNT_W-1:0] count;
        logic               possible;
    } cut_answer_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [LEN_W-1:0]   rod_length = '0;
    logic [LEN_W-1:0]   piece_len_a = '0;
    logic [LEN_W-1:0]   piece_len_b = '0;
    logic [LEN_W-1:0]   piece_len_c = '0;
    logic               result_valid;
    logic [COUNT_W-1:0] best_count;
    logic               cut_possible;

    cut_query_t  query_q[$];
    cut_answer_t answer_q[$];
    cut_query_t  cur_query;

    // Reachable flag in the top bit, best piece count below it
    bit [COUNT_W:0] reach_tab [0:MAX_LEN];

    int fail_count     = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int burst_left     = 0;
    int gap_left       = 0;

    max_rod_segments_dp_unit i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .rod_length   (rod_length),
        .piece_len_a  (piece_len_a),
        .piece_len_b  (piece_len_b),
        .piece_len_c  (piece_len_c),
        .result_valid (result_valid),
        .best_count   (best_count),
        .cut_possible (cut_possible)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Tabulate lengths 0..rod and return the best exact cut
    function automatic cut_answer_t predict_cut(input cut_query_t q);
        cut_answer_t        ans;
        bit [LEN_W-1:0]     pieces [3];
        bit [COUNT_W:0]     best;
        bit [COUNT_W:0]     prev;
        bit [COUNT_W-1:0]   cand_cnt;
        int                 n;
        int                 p;
        pieces[0] = q.pa;
        pieces[1] = q.pb;
        pieces[2] = q.pc;
        n = int'(q.rod);
        ans.count = '0;
        ans.possible = 1'b0;
        if (n > MAX_LEN) begin
            return ans;
        end
        reach_tab[0] = {1'b1, {COUNT_W{1'b0}}};
        for (int i = 1; i <= n; i++) begin
            best = '0;
            for (int k = 0; k < 3; k++) begin
                p = int'(pieces[k]);
                // A zero piece never shortens the rod; a long one never fits
                if (p != 0 && p <= i) begin
                    prev = reach_tab[i - p];
                    if (prev[COUNT_W]) begin
                        cand_cnt = prev[COUNT_W-1:0] + 1'b1;
                        if (!best[COUNT_W] || cand_cnt > best[COUNT_W-1:0]) begin
                            best = {1'b1, cand_cnt};
                        end
                    end
                end
            end
            reach_tab[i] = best;
        end
        if (reach_tab[n][COUNT_W]) begin
            ans.count = reach_tab[n][COUNT_W-1:0];
            ans.possible = 1'b1;
        end
        return ans;
    endfunction

    task automatic add_query(input int rod, input int a, input int b, input int c);
        cut_query_t q;
        q.rod = LEN_W'(rod);
        q.pa  = LEN_W'(a);
        q.pb  = LEN_W'(b);
        q.pc  = LEN_W'(c);
        query_q.push_back(q);
    endtask

    // Mostly pieces that fit the rod, now and then zero or any 10-bit value
    function automatic int pick_piece(input int rod);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) begin
            return 0;
        end
        if (r <= 3) begin
            return $urandom_range(0, (1 << LEN_W) - 1);
        end
        return $urandom_range(1, (rod < 2) ? 2 : rod);
    endfunction

    // Pick a rod length: mostly short, some medium, a few up to the table size
    function automatic int pick_rod();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) begin
            return $urandom_range(0, 63);
        end
        if (r < 95) begin
            return $urandom_range(0, 255);
        end
        return $urandom_range(0, MAX_LEN);
    endfunction

    // Drive items in bursts separated by random gaps; hold until accepted
    always @(posedge clk)
    begin : drive_blk
        logic took;
        logic next_start;
        if (!rst_n) begin
            start <= 1'b0;
        end
        else begin
            took = start && !busy;
            if (took) begin
                answer_q.push_back(predict_cut(cur_query));
            end
            next_start = start && !took;
            if (!next_start) begin
                if (gap_left > 0) begin
                    gap_left--;
                end
                else if (query_q.size() > 0) begin
                    cur_query = query_q.pop_front();
                    next_start = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end
                    else begin
                        burst_left = $urandom_range(0, 12);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
                    end
                end
            end
            start       <= next_start;
            rod_length  <= cur_query.rod;
            piece_len_a <= cur_query.pa;
            piece_len_b <= cur_query.pb;
            piece_len_c <= cur_query.pc;
        end
    end

    // Check each result against the oldest expected answer
    always @(posedge clk)
    begin : check_blk
        cut_answer_t want;
        if (rst_n && result_valid) begin
            if (answer_q.size() == 0) begin
                fail_count++;
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("unexpected result: best_count=%0d cut_possible=%0b",
                             best_count, cut_possible);
                end
            end
            else begin
                want = answer_q.pop_front();
                if (best_count !== want.count || cut_possible !== want.possible) begin
                    fail_count++;
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT) begin
                        $display("mismatch: best_count exp %0d got %0d, cut_possible exp %0b got %0b",
                                 want.count, best_count, want.possible, cut_possible);
                    end
                end
            end
        end
    end

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int rod;
        // Zero rod length is always cut with no pieces
        add_query(0, 1, 1, 1);
        add_query(0, 1023, 1023, 1023);
        add_query(0, 0, 0, 0);
        // Full-length rods
        add_query(1023, 1, 1, 1);
        add_query(1023, 1023, 1023, 1023);
        add_query(1023, 2, 4, 6);
        add_query(1023, 0, 1023, 0);
        add_query(1023, 682, 341, 1023);
        // Small exact and inexact cuts
        add_query(7, 5, 3, 2);
        add_query(11, 4, 6, 8);
        add_query(9, 2, 2, 9);
        add_query(1, 1, 2, 3);
        // Zero piece lengths are ignored
        add_query(17, 0, 0, 0);
        add_query(17, 0, 5, 3);
        add_query(12, 4, 0, 0);
        add_query(12, 0, 0, 5);
        // Pieces longer than the rod never fit
        add_query(4, 5, 6, 7);
        add_query(4, 5, 1023, 4);
        // Alternating bit patterns on every field, then mixed values
        add_query(682, 341, 682, 341);
        add_query(341, 682, 341, 682);
        add_query(512, 512, 256, 341);
        add_query(300, 7, 11, 13);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            rod = pick_rod();
            add_query(rod, pick_piece(rod), pick_piece(rod), pick_piece(rod));
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Drain stimulus and expected answers, then let the tail settle
        while (query_q.size() != 0 || start || answer_q.size() != 0) begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0) begin
            $display("tb: success");
        end
        else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
